FILE: hdl/lvd_pkg.sv
// Shared types and constants of the LZW varint decoder.
package lvd_pkg;

    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 10;
    localparam int PREV_W       = 9;
    localparam int WORD_LANES   = 8;
    localparam int WORD_W       = BYTE_W * WORD_LANES;
    localparam int COUNT_W      = 4;
    localparam int DIGIT_IDX_W  = 3;
    localparam int STACK_DEPTH  = 257;
    localparam int SP_W         = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0]      CODE_MAX      = 10'd1023;
    localparam logic [DIGIT_IDX_W-1:0] DIGIT_IDX_MAX = 3'd7;
    localparam logic [CODE_W-1:0]      FIRST_LEARNED = 10'd256;
    localparam logic [COUNT_W-1:0]     LANES_FULL    = 4'd8;

    // One finished code as handed from the front end to the back end.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              ovf;
    } code_cmd_t;

endpackage

FILE: hdl/lvd_if.sv
// Valid/ready channel interfaces for compressed bytes and decoded words.
interface lvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface lvd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_chars;
    logic [3:0]  char_count;
    logic        last_of_code;
    logic        bad_code;

    modport source (output valid, output out_chars, output char_count,
                    output last_of_code, output bad_code, input ready);
    modport sink (input valid, input out_chars, input char_count,
                  input last_of_code, input bad_code, output ready);
endinterface

FILE: hdl/lvd_front.sv
// Front end: assembles base-128 digits into codes and passes finished codes on.
module lvd_front (
    input  logic               clk,
    input  logic               rst_n,
    lvd_in_if.sink             code_bytes,
    output lvd_pkg::code_cmd_t cmd,
    output logic               cmd_valid,
    input  logic               cmd_ready
);

    logic [lvd_pkg::CODE_W-1:0]      accum_reg, accum_next;
    logic [lvd_pkg::DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic                            ovf_reg, ovf_next;

    logic [6:0]  digit;
    logic [14:0] add;
    logic [14:0] sum;
    logic        term;
    logic        ovf_now;
    logic [lvd_pkg::CODE_W-1:0] code_sat;

    // A terminating byte carries 255 minus its value; both forms fit in seven bits.
    assign digit = code_bytes.in_byte[7] ? 7'(8'd255 - code_bytes.in_byte)
                                         : code_bytes.in_byte[6:0];
    assign term  = code_bytes.in_byte[7] | code_bytes.stream_end;

    always_comb
    begin
        add = '0;
        if (idx_reg == 3'd0)
        begin
            add = 15'(digit);
        end
        else if (idx_reg == 3'd1)
        begin
            add = {1'b0, digit, 7'b0};
        end
        sum      = 15'(accum_reg) + add;
        ovf_now  = ovf_reg | ((idx_reg > 3'd1) && (digit != 7'd0))
                 | (sum > 15'(lvd_pkg::CODE_MAX));
        code_sat = (sum > 15'(lvd_pkg::CODE_MAX)) ? lvd_pkg::CODE_MAX : sum[9:0];
    end

    assign code_bytes.ready = cmd_ready;
    assign cmd_valid        = code_bytes.valid & term;
    assign cmd.code         = code_sat;
    assign cmd.ovf          = ovf_now;

    always_comb
    begin
        accum_next = accum_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        if (code_bytes.valid && cmd_ready)
        begin
            if (term)
            begin
                accum_next = '0;
                idx_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                accum_next = code_sat;
                idx_next   = (idx_reg == lvd_pkg::DIGIT_IDX_MAX) ? idx_reg : idx_reg + 3'd1;
                ovf_next   = ovf_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            accum_reg <= accum_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: hdl/lvd_fifo.sv
// Short register queue of finished codes between front end and back end.
module lvd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  lvd_pkg::code_cmd_t push_data,
    input  logic               push_valid,
    output logic               push_ready,
    output lvd_pkg::code_cmd_t pop_data,
    output logic               pop_valid,
    input  logic               pop_ready
);

    lvd_pkg::code_cmd_t slots [lvd_pkg::QUEUE_DEPTH];

    logic [lvd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lvd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lvd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != lvd_pkg::QCNT_W'(lvd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + lvd_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lvd_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + lvd_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - lvd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/lvd_back.sv
// Back end: dictionary lookup, chain walk onto a byte stack, and word packing.
module lvd_back #(
    parameter int DICT_SIZE = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lvd_pkg::code_cmd_t cmd,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    lvd_out_if.source          chars
);

    localparam int LEARN_DEPTH = DICT_SIZE - 256;
    localparam int LIDX_W      = (LEARN_DEPTH > 1) ? $clog2(LEARN_DEPTH) : 1;
    localparam logic [lvd_pkg::CODE_W-1:0] DICT_LIMIT = lvd_pkg::CODE_W'(DICT_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_POP  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [lvd_pkg::CODE_W-1:0] nfs_reg, nfs_next;
    logic [lvd_pkg::PREV_W-1:0] prev_code_reg, prev_code_next;
    logic                       have_prev_reg, have_prev_next;
    logic [7:0]                 prev_first_reg, prev_first_next;
    logic [lvd_pkg::PREV_W-1:0] cur_code_reg, cur_code_next;
    logic [lvd_pkg::PREV_W-1:0] cur_reg, cur_next;
    logic                       pending_reg, pending_next;
    logic [lvd_pkg::SP_W-1:0]   sp_reg, sp_next;
    logic [lvd_pkg::SP_W-1:0]   pos_reg, pos_next;
    logic [lvd_pkg::COUNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [lvd_pkg::COUNT_W-1:0] lane_reg, lane_next;
    logic                       byte_vld_reg, byte_vld_next;
    logic [lvd_pkg::WORD_W-1:0] word_reg, word_next;

    logic                        out_valid_reg, out_valid_next;
    logic [lvd_pkg::WORD_W-1:0]  out_chars_reg, out_chars_next;
    logic [lvd_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_bad_reg, out_bad_next;
    logic                        out_load;

    // Learned entries: prefix code and appended byte.
    logic [lvd_pkg::PREV_W-1:0] prefix_mem [LEARN_DEPTH];
    logic [7:0]                 suffix_mem [LEARN_DEPTH];
    logic [lvd_pkg::PREV_W-1:0] rd_prefix;
    logic [7:0]                 rd_suffix;
    logic                       ent_rd_en;
    logic [LIDX_W-1:0]          ent_rd_addr;
    logic                       ent_wr_en;
    logic [LIDX_W-1:0]          ent_wr_addr;

    // Byte stack: the string is pushed last byte first and popped in order.
    logic [7:0]               stack_mem [lvd_pkg::STACK_DEPTH];
    logic [7:0]               stk_q;
    logic                     stk_wr_en;
    logic [lvd_pkg::SP_W-1:0] stk_wr_addr;
    logic [7:0]               stk_wr_data;
    logic                     stk_rd_en;
    logic [lvd_pkg::SP_W-1:0] stk_rd_addr;

    logic                        special;
    logic                        bad;
    logic                        learn;
    logic                        out_free;
    logic [lvd_pkg::PREV_W-1:0]  start_code;
    logic                        issuing;
    logic [lvd_pkg::COUNT_W-1:0] placed_cnt;
    logic [lvd_pkg::WORD_W-1:0]  word_placed;

    assign special    = (cmd.code == nfs_reg);
    assign bad        = cmd.ovf || (cmd.code > nfs_reg)
                     || (special && (!have_prev_reg || (nfs_reg >= DICT_LIMIT)));
    assign learn      = have_prev_reg && (nfs_reg < DICT_LIMIT);
    assign out_free   = !out_valid_reg || chars.ready;
    assign start_code = special ? prev_code_reg : cmd.code[lvd_pkg::PREV_W-1:0];

    assign issuing    = (pos_reg != '0) && (issue_cnt_reg != lvd_pkg::LANES_FULL);
    assign placed_cnt = byte_vld_reg ? lane_reg + 4'd1 : lane_reg;

    always_comb
    begin
        word_placed = word_reg;
        for (int i = 0; i < lvd_pkg::WORD_LANES; i++)
        begin
            if (byte_vld_reg && (lane_reg == 4'(i)))
            begin
                word_placed[8*i +: 8] = stk_q;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        nfs_next        = nfs_reg;
        prev_code_next  = prev_code_reg;
        have_prev_next  = have_prev_reg;
        prev_first_next = prev_first_reg;
        cur_code_next   = cur_code_reg;
        cur_next        = cur_reg;
        pending_next    = pending_reg;
        sp_next         = sp_reg;
        pos_next        = pos_reg;
        issue_cnt_next  = issue_cnt_reg;
        lane_next       = lane_reg;
        byte_vld_next   = byte_vld_reg;
        word_next       = word_reg;
        cmd_ready       = 1'b0;
        ent_rd_en       = 1'b0;
        ent_rd_addr     = '0;
        ent_wr_en       = 1'b0;
        ent_wr_addr     = LIDX_W'(nfs_reg[7:0]);
        stk_wr_en       = 1'b0;
        stk_wr_addr     = sp_reg;
        stk_wr_data     = cur_reg[7:0];
        stk_rd_en       = 1'b0;
        stk_rd_addr     = pos_reg - 9'd1;
        out_load        = 1'b0;
        out_chars_next  = word_placed;
        out_count_next  = issue_cnt_reg;
        out_last_next   = (pos_reg == '0);
        out_bad_next    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (bad)
                    begin
                        if (out_free)
                        begin
                            cmd_ready      = 1'b1;
                            out_load       = 1'b1;
                            out_chars_next = '0;
                            out_count_next = '0;
                            out_last_next  = 1'b1;
                            out_bad_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_ready     = 1'b1;
                        cur_code_next = cmd.code[lvd_pkg::PREV_W-1:0];
                        // The special code ends in the first byte of the previous string.
                        if (special)
                        begin
                            stk_wr_en   = 1'b1;
                            stk_wr_addr = '0;
                            stk_wr_data = prev_first_reg;
                            sp_next     = 9'd1;
                        end
                        else
                        begin
                            sp_next = '0;
                        end
                        if (start_code[8])
                        begin
                            ent_rd_en    = 1'b1;
                            ent_rd_addr  = LIDX_W'(start_code[7:0]);
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            cur_next     = start_code;
                            pending_next = 1'b0;
                        end
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (pending_reg)
                begin
                    stk_wr_en   = 1'b1;
                    stk_wr_data = rd_suffix;
                    sp_next     = sp_reg + 9'd1;
                    if (rd_prefix[8])
                    begin
                        ent_rd_en    = 1'b1;
                        ent_rd_addr  = LIDX_W'(rd_prefix[7:0]);
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        cur_next     = rd_prefix;
                        pending_next = 1'b0;
                    end
                end
                else
                begin
                    // Root byte: it is the first byte of the string being decoded.
                    stk_wr_en   = 1'b1;
                    stk_wr_data = cur_reg[7:0];
                    sp_next     = sp_reg + 9'd1;
                    if (learn)
                    begin
                        ent_wr_en = 1'b1;
                        nfs_next  = nfs_reg + 10'd1;
                    end
                    prev_code_next  = cur_code_reg;
                    have_prev_next  = 1'b1;
                    prev_first_next = cur_reg[7:0];
                    pos_next        = sp_reg + 9'd1;
                    issue_cnt_next  = '0;
                    lane_next       = '0;
                    byte_vld_next   = 1'b0;
                    word_next       = '0;
                    state_next      = ST_POP;
                end
            end

            ST_POP:
            begin
                if (!issuing && (placed_cnt == issue_cnt_reg))
                begin
                    if (out_free)
                    begin
                        out_load       = 1'b1;
                        word_next      = '0;
                        lane_next      = '0;
                        issue_cnt_next = '0;
                        byte_vld_next  = 1'b0;
                        if (pos_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    word_next     = word_placed;
                    lane_next     = placed_cnt;
                    byte_vld_next = issuing;
                    if (issuing)
                    begin
                        stk_rd_en      = 1'b1;
                        pos_next       = pos_reg - 9'd1;
                        issue_cnt_next = issue_cnt_reg + 4'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (chars.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ent_wr_en)
        begin
            prefix_mem[ent_wr_addr] <= prev_code_reg;
            suffix_mem[ent_wr_addr] <= cur_reg[7:0];
        end
        if (ent_rd_en)
        begin
            rd_prefix <= prefix_mem[ent_rd_addr];
            rd_suffix <= suffix_mem[ent_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stk_q <= stack_mem[stk_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_code_reg <= cur_code_next;
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        word_reg     <= word_next;
        if (out_load)
        begin
            out_chars_reg <= out_chars_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nfs_reg        <= lvd_pkg::FIRST_LEARNED;
            prev_code_reg  <= '0;
            have_prev_reg  <= 1'b0;
            prev_first_reg <= '0;
            pending_reg    <= 1'b0;
            sp_reg         <= '0;
            issue_cnt_reg  <= '0;
            lane_reg       <= '0;
            byte_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nfs_reg        <= nfs_next;
            prev_code_reg  <= prev_code_next;
            have_prev_reg  <= have_prev_next;
            prev_first_reg <= prev_first_next;
            pending_reg    <= pending_next;
            sp_reg         <= sp_next;
            issue_cnt_reg  <= issue_cnt_next;
            lane_reg       <= lane_next;
            byte_vld_reg   <= byte_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign chars.valid        = out_valid_reg;
    assign chars.out_chars    = out_chars_reg;
    assign chars.char_count   = out_count_reg;
    assign chars.last_of_code = out_last_reg;
    assign chars.bad_code     = out_bad_reg;

`ifndef NO_ASSERTIONS
    a_nfs_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nfs_reg >= lvd_pkg::FIRST_LEARNED) && (nfs_reg <= DICT_LIMIT))
        else $error("next free slot left its range");

    a_nfs_step: assert property (@(posedge clk) disable iff (!rst_n)
        (nfs_reg != $past(nfs_reg)) |-> (nfs_reg == $past(nfs_reg) + 10'd1))
        else $error("next free slot moved by more than one");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_reg <= lvd_pkg::SP_W'(lvd_pkg::STACK_DEPTH)) &&
        (pos_reg <= lvd_pkg::SP_W'(lvd_pkg::STACK_DEPTH) || state_reg != ST_POP))
        else $error("byte stack pointer beyond stack depth");

    a_pending_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg && (state_reg != ST_WALK) |-> $past(state_reg) == ST_POP ||
        $past(state_reg) == ST_IDLE || $past(state_reg) == ST_WALK)
        else $error("dictionary read pending outside the chain walk");

    a_bad_word_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_bad_next |=> (out_count_reg == '0) && out_last_reg)
        else $error("error word carries bytes or lacks the last marker");
`endif

endmodule

FILE: hdl/lzw_varint_decoder_top.sv
// Top level of the LZW varint decoder: front end, code queue and back end.
//
// The block takes one compressed byte per word on code_bytes and returns
// decoded bytes on chars, up to eight per word, first byte in the lowest lane.
// The front end gathers base-128 digits; a byte with bit 7 set, or a word
// with stream_end set, finishes a code and places it in a four-entry queue.
// Digit bytes are taken one per cycle while the queue has room.
// The back end takes one code at a time. A bad code gives a single error
// word once the output register is free. A good code is accepted, then
// its dictionary chain is walked one byte per cycle onto a byte stack (one
// step fewer for the special code, whose last byte is stacked as it is
// accepted), then the stack is popped one byte per cycle, with a pause to
// load each output word, while chars does not stall the output register.
// The registered dictionary read and the byte stack set these rates; the
// last word of each code is marked.
// Reset empties the queue, forgets the previous string and restarts
// learning at slot 256; no clearing pass is needed. When chars is stalled
// the output register holds its word, the back end waits, and the front
// end keeps taking bytes until the queue fills.
module lzw_varint_decoder_top #(
    parameter int DICT_SIZE = 512
) (
    input  logic     clk,
    input  logic     rst_n,
    lvd_in_if.sink   code_bytes,
    lvd_out_if.source chars
);

    lvd_pkg::code_cmd_t front_cmd;
    logic               front_valid;
    logic               front_ready;
    lvd_pkg::code_cmd_t head_cmd;
    logic               head_valid;
    logic               head_ready;

    lvd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_bytes (code_bytes),
        .cmd        (front_cmd),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready)
    );

    lvd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (head_cmd),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready)
    );

    // The back end owns the dictionary, the byte stack and the output register.
    lvd_back #(
        .DICT_SIZE (DICT_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (head_valid),
        .cmd_ready (head_ready),
        .chars     (chars)
    );

endmodule

FILE: dv/tb_lzw_varint_decoder_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the LZW varint decoder: directed and random byte streams, scoreboarded.
module tb_lzw_varint_decoder_top;

    localparam int BYTE_W      = lvd_pkg::BYTE_W;
    localparam int WORD_W      = lvd_pkg::WORD_W;
    localparam int WORD_LANES  = lvd_pkg::WORD_LANES;
    localparam int COUNT_W     = lvd_pkg::COUNT_W;
    localparam int PREV_W      = lvd_pkg::PREV_W;
    localparam int CODE_W      = lvd_pkg::CODE_W;
    localparam int DIGIT_IDX_W = lvd_pkg::DIGIT_IDX_W;
    localparam int STACK_DEPTH = lvd_pkg::STACK_DEPTH;

    localparam logic [CODE_W-1:0]      FIRST_LEARNED = lvd_pkg::FIRST_LEARNED;
    localparam logic [CODE_W-1:0]      CODE_MAX      = lvd_pkg::CODE_MAX;
    localparam logic [DIGIT_IDX_W-1:0] DIGIT_IDX_MAX = lvd_pkg::DIGIT_IDX_MAX;

    localparam int DICT_SIZE        = 512;
    localparam int IDLE_PCT         = 30;
    localparam int RANDOM_ITEMS     = 440;
    localparam int AFTER_FULL_CODES = 12;
    localparam int HOLD_AFTER_WORDS = 60;
    localparam int HOLD_CYCLES      = 400;
    localparam int STEADY_FROM      = 150;
    localparam int STEADY_TO        = 260;
    localparam int MAX_SHOWN        = 10;
    localparam int STALL_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 600;
    localparam int RESET_CYCLES     = 9;

    localparam logic [BYTE_W-1:0] TERM_ZERO = 8'hFF;   // final digit with value 0

    // One decoded word as it leaves the block.
    typedef struct packed {
        logic [WORD_W-1:0]  chars;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               bad;
    } chars_word_t;

    // One entry of the stimulus queue. A drain entry carries no byte: the
    // driver stops there until every predicted word has come back.
    typedef struct packed {
        logic              drain;
        logic [BYTE_W-1:0] data;
        logic              fin;
    } stream_item_t;

    // Clock, reset and the values driven onto the input channel. The
    // initializers give every block input a known value from time zero.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [BYTE_W-1:0] in_data   = '0;
    logic              in_fin    = 1'b0;
    logic              out_ready = 1'b0;

    lvd_in_if  code_bytes_if ();
    lvd_out_if chars_if ();

    assign code_bytes_if.valid      = in_valid;
    assign code_bytes_if.in_byte    = in_data;
    assign code_bytes_if.stream_end = in_fin;
    assign chars_if.ready           = out_ready;

    lzw_varint_decoder_top #(
        .DICT_SIZE(DICT_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .code_bytes(code_bytes_if),
        .chars(chars_if)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioral decoder. It is advanced only by the driver, one call per
    // accepted byte, and appends the words that byte causes to
    // expected_words.
    // ------------------------------------------------------------------
    logic [PREV_W-1:0]      learned_prefix [256];
    logic [BYTE_W-1:0]      learned_suffix [256];
    logic [BYTE_W-1:0]      learned_first  [256];
    logic [CODE_W-1:0]      free_slot;
    logic [PREV_W-1:0]      prev_code;
    logic                   have_prev;
    logic [CODE_W-1:0]      code_sum;
    logic [DIGIT_IDX_W-1:0] digit_pos;
    logic                   code_ovf;

    chars_word_t  expected_words [$];
    stream_item_t stream_bytes [$];

    int  bytes_taken  = 0;
    int  words_seen   = 0;
    int  fail_count   = 0;
    int  hold_left    = 0;
    bit  held_once    = 1'b0;
    int  stall_cycles = 0;

    // Both sides stop idling for a while so that the block also runs at
    // full rate.
    logic steady;
    assign steady = (bytes_taken >= STEADY_FROM) && (bytes_taken < STEADY_TO);

    function automatic logic [BYTE_W-1:0] first_char(input logic [PREV_W-1:0] c);
        if (c < FIRST_LEARNED)
            return c[BYTE_W-1:0];
        return learned_first[c[BYTE_W-1:0]];
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int                digit;
        int                sum;
        int                sp;
        int                pos;
        int                cnt;
        int                guard;
        int                nres;
        logic [CODE_W-1:0] code;
        logic              ovf;
        logic              special;
        logic [PREV_W-1:0] c;
        logic [BYTE_W-1:0] fc;
        logic [BYTE_W-1:0] stack [STACK_DEPTH];
        chars_word_t       w;

        // Digit 0 weighs 1, digit 1 weighs 128; any nonzero digit further
        // up, or a sum beyond the code range, marks the code as overflowed.
        digit = b[7] ? 255 - int'(b) : int'(b);
        sum = int'(code_sum);
        if (digit_pos == 0)
            sum += digit;
        else if (digit_pos == 1)
            sum += digit * 128;
        else if (digit != 0)
            code_ovf = 1'b1;
        if (sum > int'(CODE_MAX))
        begin
            code_ovf = 1'b1;
            sum = int'(CODE_MAX);
        end
        code_sum = CODE_W'(sum);
        if (digit_pos < DIGIT_IDX_MAX)
            digit_pos++;

        if (!(b[7] || fin))
            return;

        code = code_sum;
        ovf = code_ovf;
        code_sum = '0;
        digit_pos = '0;
        code_ovf = 1'b0;

        // The code one past the dictionary needs a previous string and
        // room to learn; anything larger is never valid.
        special = (code == free_slot);
        if (ovf || code > free_slot || (special && (!have_prev || free_slot >= DICT_SIZE)))
        begin
            w = '0;
            w.last = 1'b1;
            w.bad = 1'b1;
            expected_words.push_back(w);
            return;
        end

        sp = 0;
        if (special)
        begin
            fc = first_char(prev_code);
            stack[0] = fc;
            sp = 1;
            c = prev_code;
        end
        else
        begin
            c = code[PREV_W-1:0];
            fc = first_char(c);
        end

        // Walk the chain from the last byte back to the root byte.
        guard = 0;
        while (c >= FIRST_LEARNED && guard < STACK_DEPTH && sp < STACK_DEPTH - 1)
        begin
            stack[sp] = learned_suffix[c[BYTE_W-1:0]];
            sp++;
            c = learned_prefix[c[BYTE_W-1:0]];
            guard++;
        end
        if (sp < STACK_DEPTH)
        begin
            stack[sp] = c[BYTE_W-1:0];
            sp++;
        end

        // Learning stops for good once the dictionary is full.
        if (have_prev && free_slot < DICT_SIZE)
        begin
            learned_prefix[free_slot[BYTE_W-1:0]] = prev_code;
            learned_suffix[free_slot[BYTE_W-1:0]] = fc;
            learned_first[free_slot[BYTE_W-1:0]]  = first_char(prev_code);
            free_slot++;
        end
        prev_code = code[PREV_W-1:0];
        have_prev = 1'b1;

        // Pop the stack into words of up to eight bytes, first byte lowest.
        pos = sp;
        nres = 0;
        while (pos > 0 || nres == 0)
        begin
            w = '0;
            cnt = 0;
            while (cnt < WORD_LANES && pos > 0)
            begin
                pos--;
                w.chars[8*cnt +: 8] = stack[pos];
                cnt++;
            end
            w.count = COUNT_W'(cnt);
            w.last = (pos == 0);
            expected_words.push_back(w);
            nres++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builder. It keeps only the dictionary fill level and the
    // previous-string flag, enough to aim codes at live entries, at the
    // special code and just past the end of the dictionary.
    // ------------------------------------------------------------------
    int gen_free;
    bit gen_prev;
    int gen_items;

    function automatic void push_byte(input logic [BYTE_W-1:0] data, input logic fin);
        stream_item_t it;
        it.drain = 1'b0;
        it.data = data;
        it.fin = fin;
        stream_bytes.push_back(it);
        gen_items++;
    endfunction

    function automatic void push_drain();
        stream_item_t it;
        it = '0;
        it.drain = 1'b1;
        stream_bytes.push_back(it);
    endfunction

    function automatic void note_code(input int code, input bit ovf);
        bit special;
        special = (code == gen_free);
        if (ovf || code > gen_free || (special && (!gen_prev || gen_free >= DICT_SIZE)))
            return;
        if (gen_prev && gen_free < DICT_SIZE)
            gen_free++;
        gen_prev = 1'b1;
    endfunction

    // Sends a code as one or two digits. Now and then the final digit is a
    // plain byte ended by stream_end, or a final byte that also ends the
    // stream.
    function automatic void send_code(input int code);
        int style;
        int hi;
        style = $urandom_range(9);
        if (code < 128)
        begin
            if (style == 0)
                push_byte(BYTE_W'(code), 1'b1);
            else
                push_byte(BYTE_W'(255 - code), style == 1);
        end
        else
        begin
            hi = code / 128;
            push_byte(BYTE_W'(code % 128), 1'b0);
            if (style == 0)
                push_byte(BYTE_W'(hi), 1'b1);
            else
                push_byte(BYTE_W'(255 - hi), style == 1);
        end
        note_code(code, code > CODE_MAX);
    endfunction

    // Random byte patterns that are still complete codes, so that the
    // builder knows what they do to the dictionary.
    function automatic void send_noise();
        int                d0;
        int                d1;
        int                code;
        int                n;
        logic [BYTE_W-1:0] b;
        logic              fin;
        case ($urandom_range(3))
            0:
            begin
                b = BYTE_W'($urandom_range(255));
                fin = b[7] ? 1'($urandom_range(1)) : 1'b1;
                push_byte(b, fin);
                note_code(b[7] ? 255 - int'(b) : int'(b), 1'b0);
            end
            1:
            begin
                d0 = $urandom_range(127);
                b = BYTE_W'($urandom_range(255));
                fin = b[7] ? 1'($urandom_range(1)) : 1'b1;
                push_byte(BYTE_W'(d0), 1'b0);
                push_byte(b, fin);
                d1 = b[7] ? 255 - int'(b) : int'(b);
                code = d0 + 128 * d1;
                note_code(code, code > CODE_MAX);
            end
            2:
            begin
                // A nonzero third digit always overflows.
                push_byte(BYTE_W'($urandom_range(127)), 1'b0);
                push_byte(BYTE_W'($urandom_range(127)), 1'b0);
                if ($urandom_range(1))
                    push_byte(BYTE_W'($urandom_range(254, 128)), 1'($urandom_range(1)));
                else
                    push_byte(BYTE_W'($urandom_range(127, 1)), 1'b1);
            end
            default:
            begin
                // Trailing zero digits are harmless, even past the point
                // where the digit position stops counting.
                d0 = $urandom_range(127);
                n = $urandom_range(8, 1);
                push_byte(BYTE_W'(d0), 1'b0);
                repeat (n) push_byte(8'h00, 1'b0);
                push_byte(TERM_ZERO, 1'($urandom_range(1)));
                note_code(d0, 1'b0);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver. An offered word stays on the channel until it is taken; a
    // new one is picked only after that, so valid is assigned once per
    // edge. Every accepted byte goes through the behavioral decoder.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        stream_item_t head;
        logic         next_valid;
        int           i;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_fin <= 1'b0;
            for (i = 0; i < 256; i++)
            begin
                learned_prefix[i] = '0;
                learned_suffix[i] = '0;
                learned_first[i] = '0;
            end
            free_slot = FIRST_LEARNED;
            prev_code = '0;
            have_prev = 1'b0;
            code_sum = '0;
            digit_pos = '0;
            code_ovf = 1'b0;
        end
        else
        begin
            if (in_valid && code_bytes_if.ready)
            begin
                decode_byte(in_data, in_fin);
                bytes_taken <= bytes_taken + 1;
            end
            if (!(in_valid && !code_bytes_if.ready))
            begin
                next_valid = 1'b0;
                if (stream_bytes.size() != 0 && stream_bytes[0].drain &&
                    expected_words.size() == 0)
                    void'(stream_bytes.pop_front());
                // While the receiver is held off the sender never idles, so
                // the code queue inside the block fills and ready drops.
                if (stream_bytes.size() != 0 && !stream_bytes[0].drain &&
                    (steady || hold_left != 0 || $urandom_range(99) >= IDLE_PCT))
                begin
                    head = stream_bytes.pop_front();
                    next_valid = 1'b1;
                    in_data <= head.data;
                    in_fin <= head.fin;
                end
                in_valid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each accepted word is checked against the oldest prediction.
    // Ready idles at random outside the steady window, except for one long hold-off counted here.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_words
        chars_word_t want;
        chars_word_t got;
        logic        next_ready;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            held_once <= 1'b0;
        end
        else
        begin
            if (chars_if.valid && out_ready)
            begin
                got.chars = chars_if.out_chars;
                got.count = chars_if.char_count;
                got.last = chars_if.last_of_code;
                got.bad = chars_if.bad_code;
                words_seen <= words_seen + 1;
                if (expected_words.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < MAX_SHOWN)
                        $display("word %0d not predicted: chars=%h count=%0d last=%0b bad=%0b",
                                 words_seen, got.chars, got.count, got.last, got.bad);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.chars !== want.chars || got.count !== want.count ||
                        got.last !== want.last || got.bad !== want.bad)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < MAX_SHOWN)
                            $display({"word %0d mismatch: expected chars=%h count=%0d last=%0b",
                                      " bad=%0b, got chars=%h count=%0d last=%0b bad=%0b"},
                                     words_seen, want.chars, want.count, want.last, want.bad,
                                     got.chars, got.count, got.last, got.bad);
                    end
                end
            end

            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                next_ready = 1'b0;
            end
            else if (!held_once && words_seen >= HOLD_AFTER_WORDS)
            begin
                hold_left <= HOLD_CYCLES;
                held_once <= 1'b1;
                next_ready = 1'b0;
            end
            else
                next_ready = steady || ($urandom_range(99) >= IDLE_PCT);
            out_ready <= next_ready;
        end
    end

    // Cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && code_bytes_if.ready) || (chars_if.valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence: build the whole stream, release reset, then wait for
    // the last byte, the last word and a quiet tail.
    // ------------------------------------------------------------------
    initial
    begin : run_stream
        int directed_items;
        int after_full;
        int r;
        int nf;
        bit mid_drain;

        gen_free = FIRST_LEARNED;
        gen_prev = 1'b0;
        gen_items = 0;
        after_full = 0;
        mid_drain = 1'b0;

        // Special code before any previous string exists: an error word.
        send_code(FIRST_LEARNED);
        // Smallest and largest one-byte codes; the second one learns 256.
        send_code(0);
        send_code(127);
        // The special code with a previous string: old string plus its own
        // first byte.
        send_code(FIRST_LEARNED + 1);
        // Largest single-byte literal, sent as two digits.
        send_code(255);
        // Largest code value, far past the dictionary.
        send_code(CODE_MAX);
        // Second digit pushes the sum out of range.
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        // Nonzero third digit.
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFE, 1'b0);
        // Zero digits until the digit position stops counting; still code 3.
        push_byte(8'h03, 1'b0);
        repeat (7) push_byte(8'h00, 1'b0);
        push_byte(TERM_ZERO, 1'b0);
        note_code(3, 1'b0);
        // Stream end on a plain byte, then on a final byte.
        push_byte(8'h41, 1'b1);
        note_code(8'h41, 1'b0);
        push_byte(8'hC0, 1'b1);
        note_code(255 - 8'hC0, 1'b0);
        directed_items = gen_items;
        push_drain();

        // Random part: run until the dictionary has filled and a few codes
        // have been decoded against the full dictionary. One-byte literals
        // are frequent so that the dictionary fills within the byte budget.
        while ((gen_items - directed_items < RANDOM_ITEMS || gen_free < DICT_SIZE ||
                after_full < AFTER_FULL_CODES) && gen_items - directed_items < 4 * RANDOM_ITEMS)
        begin
            nf = gen_free;
            if (nf >= DICT_SIZE)
                after_full++;
            r = $urandom_range(99);
            if (r < 25)
                send_code(nf);
            else if (r < 40)
                send_code(nf - 1 - int'($urandom_range(7)));
            else if (r < 50)
                send_code($urandom_range(nf - 1));
            else if (r < 88)
                send_code($urandom_range(127));
            else if (r < 92)
                send_code($urandom_range(CODE_MAX, nf + 1));
            else
                send_noise();
            if (!mid_drain && gen_items - directed_items >= RANDOM_ITEMS / 2)
            begin
                push_drain();
                mid_drain = 1'b1;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lvd_pkg.sv
hdl/lvd_if.sv
hdl/lvd_front.sv
hdl/lvd_fifo.sv
hdl/lvd_back.sv
hdl/lzw_varint_decoder_top.sv
dv/tb_lzw_varint_decoder_top.sv
